// ----- sv/alrc_pkg.sv -----
// Types and constants shared by the automatic light relay controller.
package alrc_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] reference_level;
    logic [7:0] sensor_level;
  } req_t;

  typedef struct packed {
    logic main_relay;
    logic second_relay;
    logic indicator_led;
    logic blink_active;
  } rsp_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned PeriodW  = 11;

  localparam logic [CfgIdxW-1:0] CFG_HIGH_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MID_THRESHOLD  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_COUNT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_COUNT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLOW_PERIOD    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FAST_BASE      = 3'd5;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [7:0] REF_FORCE_OFF = 8'd0;
  localparam logic [7:0] REF_FORCE_ON  = 8'd255;

  localparam logic [7:0]         HIGH_THRESHOLD_RST = 8'd100;
  localparam logic [7:0]         MID_THRESHOLD_RST  = 8'd50;
  localparam logic [3:0]         CONFIRM_COUNT_RST  = 4'd2;
  localparam logic [7:0]         HOLD_COUNT_RST     = 8'd60;
  localparam logic [9:0]         SLOW_PERIOD_RST    = 10'd500;
  localparam logic [7:0]         FAST_BASE_RST      = 8'd10;
  localparam logic [PeriodW-1:0] BLINK_PERIOD_RST   = 11'd100;

endpackage

// ----- sv/auto_light_relay_control.sv -----
// Automatic light relay controller: sample and tick evaluation with registered result.
//
// Every accepted transaction, tick or sample, yields exactly one result carrying the
// relay, LED and blink state after that transaction. A transaction is taken into an
// input register, evaluated combinationally against the controller state and written to
// the result register, so the block accepts one transaction per clock while results are
// taken. The rate is set by the state update loop, which closes through the state
// register alone. While a result waits, the input register takes one further transaction
// and the input then stalls until the waiting result is taken.
// Configuration writes take effect at once and must be made while the block is idle.
module auto_light_relay_control (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [alrc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [alrc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  alrc_pkg::req_t                       in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output alrc_pkg::rsp_t                       out_rsp_o
);

  typedef struct packed {
    logic                              led_level;
    logic                              relay_a;
    logic                              relay_b;
    logic                              blink_on;
    logic [alrc_pkg::PeriodW-1:0]      blink_period;
    logic [alrc_pkg::PeriodW-1:0]      tick_count;
    logic [3:0]                        dusk_confirm;
    logic [3:0]                        dark_confirm;
    logic [7:0]                        bright_hold;
    logic [7:0]                        dusk_hold;
  } ctrl_state_t;

  logic [7:0] high_threshold_q;
  logic [7:0] mid_threshold_q;
  logic [3:0] confirm_count_q;
  logic [7:0] hold_count_q;
  logic [9:0] slow_period_q;
  logic [7:0] fast_base_q;

  logic           in_valid_q;
  alrc_pkg::req_t in_q;
  logic           out_valid_q;
  alrc_pkg::rsp_t out_q;
  alrc_pkg::rsp_t out_d;
  ctrl_state_t    st_q;
  ctrl_state_t    st_d;
  logic           fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_threshold_q <= alrc_pkg::HIGH_THRESHOLD_RST;
      mid_threshold_q  <= alrc_pkg::MID_THRESHOLD_RST;
      confirm_count_q  <= alrc_pkg::CONFIRM_COUNT_RST;
      hold_count_q     <= alrc_pkg::HOLD_COUNT_RST;
      slow_period_q    <= alrc_pkg::SLOW_PERIOD_RST;
      fast_base_q      <= alrc_pkg::FAST_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alrc_pkg::CFG_HIGH_THRESHOLD: high_threshold_q <= cfg_wdata_i[7:0];
        alrc_pkg::CFG_MID_THRESHOLD:  mid_threshold_q  <= cfg_wdata_i[7:0];
        alrc_pkg::CFG_CONFIRM_COUNT:  confirm_count_q  <= cfg_wdata_i[3:0];
        alrc_pkg::CFG_HOLD_COUNT:     hold_count_q     <= cfg_wdata_i[7:0];
        alrc_pkg::CFG_SLOW_PERIOD:    slow_period_q    <= cfg_wdata_i[9:0];
        alrc_pkg::CFG_FAST_BASE:      fast_base_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  always_comb begin
    logic [7:0]                   diff;
    logic [alrc_pkg::PeriodW-1:0] tc;
    st_d = st_q;
    diff = in_q.reference_level - in_q.sensor_level;
    tc   = st_q.tick_count + 11'd1;
    if (in_q.req_type == alrc_pkg::REQ_SAMPLE) begin
      if (in_q.reference_level == alrc_pkg::REF_FORCE_OFF) begin
        st_d.led_level = 1'b0;
        st_d.relay_a   = 1'b0;
        st_d.blink_on  = 1'b0;
      end else if (in_q.reference_level == alrc_pkg::REF_FORCE_ON) begin
        st_d.led_level = 1'b1;
        st_d.relay_a   = 1'b0;
        st_d.blink_on  = 1'b0;
      end else begin
        if (diff >= high_threshold_q) begin
          st_d.blink_period = {1'b0, slow_period_q};
          st_d.blink_on     = 1'b0;
          st_d.led_level    = 1'b1;
        end
        if (diff >= mid_threshold_q && diff < high_threshold_q) begin
          st_d.blink_period = {1'b0, slow_period_q};
          st_d.blink_on     = 1'b1;
          st_d.dusk_hold    = 8'd0;
          st_d.dark_confirm = 4'd0;
          st_d.dusk_confirm = 4'd0;
        end
        if (diff != 8'd0 && diff < mid_threshold_q) begin
          if (st_d.dusk_confirm < confirm_count_q) begin
            st_d.dusk_confirm = st_d.dusk_confirm + 4'd1;
          end else begin
            st_d.blink_period = {3'b000, fast_base_q} + {2'b00, diff, 1'b0};
            st_d.blink_on     = 1'b1;
            st_d.relay_a      = 1'b1;
            st_d.bright_hold  = 8'd0;
            st_d.dark_confirm = 4'd0;
            if (st_d.dusk_hold < hold_count_q) begin
              st_d.dusk_hold = st_d.dusk_hold + 8'd1;
            end else begin
              st_d.relay_b = 1'b0;
            end
          end
        end
        if (in_q.sensor_level >= in_q.reference_level) begin
          if (st_d.dark_confirm < confirm_count_q) begin
            st_d.dark_confirm = st_d.dark_confirm + 4'd1;
          end else begin
            st_d.relay_a      = 1'b1;
            st_d.relay_b      = 1'b1;
            st_d.blink_on     = 1'b0;
            st_d.led_level    = 1'b0;
            st_d.bright_hold  = 8'd0;
            st_d.dusk_hold    = 8'd0;
            st_d.dusk_confirm = 4'd0;
          end
        end else begin
          if (st_d.bright_hold < hold_count_q) begin
            st_d.bright_hold = st_d.bright_hold + 8'd1;
          end else begin
            st_d.relay_a      = 1'b0;
            st_d.relay_b      = 1'b0;
            st_d.dusk_hold    = 8'd0;
            st_d.dark_confirm = 4'd0;
          end
        end
      end
    end else if (st_q.blink_on) begin
      if (tc >= st_q.blink_period) begin
        st_d.led_level  = !st_q.led_level;
        st_d.tick_count = '0;
      end else begin
        st_d.tick_count = tc;
      end
    end
    out_d.main_relay    = st_d.relay_a;
    out_d.second_relay  = st_d.relay_b;
    out_d.indicator_led = st_d.led_level;
    out_d.blink_active  = st_d.blink_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.led_level    <= 1'b1;
      st_q.relay_a      <= 1'b0;
      st_q.relay_b      <= 1'b0;
      st_q.blink_on     <= 1'b0;
      st_q.blink_period <= alrc_pkg::BLINK_PERIOD_RST;
      st_q.tick_count   <= '0;
      st_q.dusk_confirm <= 4'd0;
      st_q.dark_confirm <= 4'd0;
      st_q.bright_hold  <= 8'd0;
      st_q.dusk_hold    <= 8'd0;
      out_valid_q       <= 1'b0;
    end else begin
      if (fire) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_tick_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.blink_on |=> $stable(st_q.tick_count))
    else $error("tick counter moved while blinking was off");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_q.main_relay == st_q.relay_a && out_q.second_relay == st_q.relay_b
             && out_q.indicator_led == st_q.led_level
             && out_q.blink_active == st_q.blink_on)
    else $error("result register does not reflect the updated state");

  a_blink_starts_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q.blink_on) |-> $past(fire && in_q.req_type == alrc_pkg::REQ_SAMPLE))
    else $error("blinking enabled without a sample transaction");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while the pipeline could advance");
`endif

endmodule

// ----- dv/auto_light_relay_control_tb.sv -----
// Self-checking testbench for the automatic light relay controller.
`timescale 1ns / 100ps

module auto_light_relay_control_tb;

  localparam int unsigned IdxW        = alrc_pkg::CfgIdxW;
  localparam int unsigned DataW       = alrc_pkg::CfgDataW;
  localparam int unsigned PerW        = alrc_pkg::PeriodW;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumRegs     = 2 ** IdxW;

  typedef enum int unsigned {SET_TIDY, SET_MIN, SET_MAX, SET_WILD} set_kind_e;
  typedef enum int unsigned {BAND_BRIGHT, BAND_MID, BAND_DUSK, BAND_DARK} band_e;

  class light_scoreboard_t;
    logic [7:0]             high_thr, mid_thr, hold_lim, fast_base;
    logic [3:0]             confirm_lim;
    logic [9:0]             slow_period;
    logic                   led, relay_a, relay_b, blink;
    logic [PerW-1:0]        period, tick_cnt;
    logic [3:0]             dusk_conf, dark_conf;
    logic [7:0]             bright_hold, dusk_hold;
    alrc_pkg::rsp_t         expected_q[$];
    int unsigned            mismatches;

    function new();
      high_thr    = alrc_pkg::HIGH_THRESHOLD_RST;
      mid_thr     = alrc_pkg::MID_THRESHOLD_RST;
      confirm_lim = alrc_pkg::CONFIRM_COUNT_RST;
      hold_lim    = alrc_pkg::HOLD_COUNT_RST;
      slow_period = alrc_pkg::SLOW_PERIOD_RST;
      fast_base   = alrc_pkg::FAST_BASE_RST;
      led         = 1'b1;
      relay_a     = 1'b0;
      relay_b     = 1'b0;
      blink       = 1'b0;
      period      = alrc_pkg::BLINK_PERIOD_RST;
      tick_cnt    = '0;
      dusk_conf   = '0;
      dark_conf   = '0;
      bright_hold = '0;
      dusk_hold   = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] val);
      case (idx)
        alrc_pkg::CFG_HIGH_THRESHOLD: high_thr    = val[7:0];
        alrc_pkg::CFG_MID_THRESHOLD:  mid_thr     = val[7:0];
        alrc_pkg::CFG_CONFIRM_COUNT:  confirm_lim = val[3:0];
        alrc_pkg::CFG_HOLD_COUNT:     hold_lim    = val[7:0];
        alrc_pkg::CFG_SLOW_PERIOD:    slow_period = val[9:0];
        alrc_pkg::CFG_FAST_BASE:      fast_base   = val[7:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [7:0] ref_lvl, logic [7:0] sen_lvl);
      logic [7:0] d;
      if (ref_lvl == alrc_pkg::REF_FORCE_OFF) begin
        led = 1'b0; relay_a = 1'b0; blink = 1'b0;
        return;
      end
      if (ref_lvl == alrc_pkg::REF_FORCE_ON) begin
        led = 1'b1; relay_a = 1'b0; blink = 1'b0;
        return;
      end
      d = ref_lvl - sen_lvl;
      if (d >= high_thr) begin
        period = {1'b0, slow_period};
        blink  = 1'b0;
        led    = 1'b1;
      end
      if (d >= mid_thr && d < high_thr) begin
        period    = {1'b0, slow_period};
        blink     = 1'b1;
        dusk_hold = '0; dark_conf = '0; dusk_conf = '0;
      end
      if (d > 0 && d < mid_thr) begin
        if (dusk_conf < confirm_lim) begin
          dusk_conf = dusk_conf + 4'd1;
        end else begin
          period      = {3'b0, fast_base} + {2'b0, d, 1'b0};
          blink       = 1'b1;
          relay_a     = 1'b1;
          bright_hold = '0; dark_conf = '0;
          if (dusk_hold < hold_lim) dusk_hold = dusk_hold + 8'd1;
          else relay_b = 1'b0;
        end
      end
      if (sen_lvl >= ref_lvl) begin
        if (dark_conf < confirm_lim) begin
          dark_conf = dark_conf + 4'd1;
        end else begin
          relay_a = 1'b1; relay_b = 1'b1;
          blink   = 1'b0; led     = 1'b0;
          bright_hold = '0; dusk_hold = '0; dusk_conf = '0;
        end
      end else begin
        if (bright_hold < hold_lim) begin
          bright_hold = bright_hold + 8'd1;
        end else begin
          relay_a = 1'b0; relay_b = 1'b0;
          dusk_hold = '0; dark_conf = '0;
        end
      end
    endfunction

    function void note_input(alrc_pkg::req_t req);
      alrc_pkg::rsp_t exp_rsp;
      if (req.req_type == alrc_pkg::REQ_SAMPLE) begin
        take_sample(req.reference_level, req.sensor_level);
      end else if (blink) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= period) begin
          led      = ~led;
          tick_cnt = '0;
        end
      end
      exp_rsp.main_relay    = relay_a;
      exp_rsp.second_relay  = relay_b;
      exp_rsp.indicator_led = led;
      exp_rsp.blink_active  = blink;
      expected_q.push_back(exp_rsp);
    endfunction

    function void check_result(alrc_pkg::rsp_t got);
      alrc_pkg::rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.main_relay !== exp_rsp.main_relay ||
          got.second_relay !== exp_rsp.second_relay ||
          got.indicator_led !== exp_rsp.indicator_led ||
          got.blink_active !== exp_rsp.blink_active) begin
        mismatches++;
        if (mismatches <= 10) $display("result differs: expected %p, got %p", exp_rsp, got);
      end
    endfunction

    function int unsigned pending();
      return unsigned'(expected_q.size());
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [IdxW-1:0]     cfg_idx_i   = '0;
  logic [DataW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  alrc_pkg::req_t      in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  alrc_pkg::rsp_t      out_rsp_o;

  light_scoreboard_t sb = new();
  int unsigned     cycles       = 0;
  int unsigned     sent         = 0;
  bit              quiet        = 1'b0;
  bit              gaps_on      = 1'b1;
  bit              hold_off_req = 1'b0;

  auto_light_relay_control u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("auto_light_relay_control: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_req_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic alrc_pkg::req_t make_sample(logic [7:0] ref_lvl, logic [7:0] sen_lvl);
    alrc_pkg::req_t req;
    req.req_type        = alrc_pkg::REQ_SAMPLE;
    req.reference_level = ref_lvl;
    req.sensor_level    = sen_lvl;
    return req;
  endfunction

  function automatic alrc_pkg::req_t make_tick();
    alrc_pkg::req_t req;
    req.req_type        = alrc_pkg::REQ_TICK;
    req.reference_level = 8'($urandom);
    req.sensor_level    = 8'($urandom);
    return req;
  endfunction

  function automatic alrc_pkg::req_t band_sample(band_e band);
    logic [7:0] ref_lvl;
    logic [7:0] d;
    int         lo;
    int         hi;
    ref_lvl = 8'($urandom_range(1, 254));
    lo = 1;
    hi = 255;
    case (band)
      BAND_BRIGHT: begin lo = int'(sb.high_thr); hi = 255; end
      BAND_MID:    begin lo = int'(sb.mid_thr); hi = int'(sb.high_thr) - 1; end
      BAND_DUSK:   begin lo = 1; hi = int'(sb.mid_thr) - 1; end
      default:     return make_sample(ref_lvl, 8'($urandom_range(32'(ref_lvl), 255)));
    endcase
    if (lo > hi) d = 8'($urandom);
    else d = 8'($urandom_range(unsigned'(hi), unsigned'(lo)));
    return make_sample(ref_lvl, ref_lvl - d);
  endfunction

  task automatic offer_item(input alrc_pkg::req_t req);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_settings(input set_kind_e kind);
    logic [DataW-1:0] vals [NumRegs];
    foreach (vals[i]) vals[i] = DataW'($urandom);
    case (kind)
      SET_MIN: foreach (vals[i]) vals[i] = '0;
      SET_MAX: foreach (vals[i]) vals[i] = '1;
      SET_TIDY: begin
        vals[alrc_pkg::CFG_HIGH_THRESHOLD] = DataW'($urandom_range(60, 220));
        vals[alrc_pkg::CFG_MID_THRESHOLD]  =
          DataW'($urandom_range(5, 32'(vals[alrc_pkg::CFG_HIGH_THRESHOLD])));
        vals[alrc_pkg::CFG_CONFIRM_COUNT]  = DataW'($urandom_range(0, 3));
        vals[alrc_pkg::CFG_HOLD_COUNT]     = DataW'($urandom_range(0, 10));
        vals[alrc_pkg::CFG_SLOW_PERIOD]    = DataW'($urandom_range(0, 25));
        vals[alrc_pkg::CFG_FAST_BASE]      = DataW'($urandom_range(0, 12));
      end
      default: ;
    endcase
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= IdxW'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(IdxW'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    set_kind_e   plan [8];
    int unsigned phase;
    int unsigned run_len;
    int unsigned pick;
    band_e       band;
    plan = '{SET_TIDY, SET_MIN, SET_TIDY, SET_MAX, SET_WILD, SET_TIDY, SET_WILD, SET_TIDY};
    phase = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(make_tick());
    offer_item(make_sample(alrc_pkg::REF_FORCE_OFF, 8'hA5));
    offer_item(make_sample(alrc_pkg::REF_FORCE_ON, 8'h5A));
    offer_item(make_sample(8'd200, 8'd0));
    offer_item(make_sample(8'd120, 8'd50));
    repeat (3) offer_item(make_tick());
    repeat (3) offer_item(make_sample(8'd60, 8'd40));
    repeat (3) offer_item(make_sample(8'd40, 8'd40));
    offer_item(make_sample(8'd10, 8'd200));
    offer_item(make_sample(8'd1, 8'd0));
    offer_item(make_sample(8'd254, 8'd255));
    offer_item(make_sample(8'd128, 8'd255));
    offer_item(make_sample(alrc_pkg::REF_FORCE_ON, 8'd255));
    offer_item(make_sample(alrc_pkg::REF_FORCE_OFF, 8'd0));
    offer_item(make_tick());

    sent = 0;
    while (sent < RandomItems) begin
      if (sent >= phase * PhaseItems && phase < 8) begin
        drain();
        program_settings(plan[phase]);
        gaps_on = $urandom_range(0, 3) != 0;
        if (phase == 2) hold_off_req = 1'b1;
        phase++;
      end
      quiet = sent >= RandomItems * 7 / 8;
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
        run_len = $urandom_range(1, 40);
        repeat (run_len) offer_item(make_tick());
      end else if (pick < 85) begin
        band    = band_e'($urandom_range(0, 3));
        run_len = $urandom_range(1, 20);
        repeat (run_len) offer_item(band_sample(band));
      end else begin
        run_len = $urandom_range(1, 5);
        repeat (run_len) begin
          if ($urandom_range(0, 2) == 0)
            offer_item(make_sample($urandom_range(0, 1) ? alrc_pkg::REF_FORCE_ON
                                                        : alrc_pkg::REF_FORCE_OFF,
                                   8'($urandom)));
          else
            offer_item(make_sample(8'($urandom), 8'($urandom)));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("auto_light_relay_control: match");
    end else begin
      $display("auto_light_relay_control: mismatch");
    end
    $finish;
  end

endmodule

// ----- auto_light_relay_control.f -----
sv/alrc_pkg.sv
sv/auto_light_relay_control.sv
dv/auto_light_relay_control_tb.sv
